// File: sv/tea_pkg.sv
// Shared types, constants and round functions for the TEA block encryption core.
// Depends on nothing; every other file of the core refers to it by scoped names.

package tea_pkg;

   // Word and block geometry.
   localparam int WORD_WIDTH = 32;
   localparam int KEY_WORD_COUNT = 4;
   localparam int CSR_INDEX_WIDTH = 8;

   // Number of full rounds; each round is split over two half-round cells.
   localparam int ROUND_COUNT = 32;
   localparam int CELL_COUNT = 2 * ROUND_COUNT;

   // Key schedule constant added to the running sum once per round.
   localparam logic [WORD_WIDTH-1:0] TEA_DELTA = 32'h9E37_79B9;

   // Key register indexes on the configuration port.
   localparam logic [CSR_INDEX_WIDTH-1:0] KEY_WORD0_INDEX = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] KEY_WORD1_INDEX = 8'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] KEY_WORD2_INDEX = 8'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] KEY_WORD3_INDEX = 8'd3;

   // Key values after reset.
   localparam logic [WORD_WIDTH-1:0] KEY_WORD0_RESET = 32'h0123_4567;
   localparam logic [WORD_WIDTH-1:0] KEY_WORD1_RESET = 32'h89AB_CDEF;
   localparam logic [WORD_WIDTH-1:0] KEY_WORD2_RESET = 32'hFEDC_BA98;
   localparam logic [WORD_WIDTH-1:0] KEY_WORD3_RESET = 32'h7654_3210;

   typedef logic [WORD_WIDTH-1:0] word_type;

   // The two halves of a block as they travel along the chain of cells.
   typedef struct packed {
      word_type left;
      word_type right;
   } word_pair_type;

   typedef word_type [KEY_WORD_COUNT-1:0] key_type;

   // TEA mixing function of one half round.
   function automatic word_type mix_word(input word_type x, input word_type sum,
                                         input word_type ka, input word_type kb);
      word_type p;
      word_type q;
      word_type r;
      p = (x << 4) + ka;
      q = x + sum;
      r = (x >> 5) + kb;
      return p ^ q ^ r;
   endfunction

   // Running sum used in a given round (counted from zero); folded at elaboration.
   function automatic word_type round_sum(input int round);
      logic [2*WORD_WIDTH-1:0] product;
      product = (2*WORD_WIDTH)'(TEA_DELTA) * (2*WORD_WIDTH)'(round + 1);
      return product[WORD_WIDTH-1:0];
   endfunction

endpackage

// File: sv/tea_req_if.sv
// Handshake channel that carries plaintext words into the TEA core.
// Depends on tea_pkg for the word type.

interface tea_req_if;
   logic               valid;
   logic               ready;
   tea_pkg::word_type  plain_left;
   tea_pkg::word_type  plain_right;

   modport source (output valid, output plain_left, output plain_right, input ready);
   modport sink   (input valid, input plain_left, input plain_right, output ready);
endinterface

// File: sv/tea_rsp_if.sv
// Handshake channel that carries ciphertext words out of the TEA core.
// Depends on tea_pkg for the word type.

interface tea_rsp_if;
   logic               valid;
   logic               ready;
   tea_pkg::word_type  cipher_left;
   tea_pkg::word_type  cipher_right;

   modport source (output valid, output cipher_left, output cipher_right, input ready);
   modport sink   (input valid, input cipher_left, input cipher_right, output ready);
endinterface

// File: sv/tea_key_regs.sv
// Key register file of the TEA core, written through the plain configuration port.
// Depends on tea_pkg for the register indexes and reset values.

module tea_key_regs (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [tea_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  tea_pkg::word_type                    csr_wdata,
   output tea_pkg::key_type                     key
);

   tea_pkg::key_type key_ff;
   tea_pkg::key_type key_in;

   // Decode the register index; writes to unknown indexes are dropped.
   always_comb begin
      key_in = key_ff;
      if (csr_we) begin
         case (csr_index)
            tea_pkg::KEY_WORD0_INDEX: key_in[0] = csr_wdata;
            tea_pkg::KEY_WORD1_INDEX: key_in[1] = csr_wdata;
            tea_pkg::KEY_WORD2_INDEX: key_in[2] = csr_wdata;
            tea_pkg::KEY_WORD3_INDEX: key_in[3] = csr_wdata;
            default: key_in = key_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff[0] <= tea_pkg::KEY_WORD0_RESET;
         key_ff[1] <= tea_pkg::KEY_WORD1_RESET;
         key_ff[2] <= tea_pkg::KEY_WORD2_RESET;
         key_ff[3] <= tea_pkg::KEY_WORD3_RESET;
      end else begin
         key_ff <= key_in;
      end
   end

   assign key = key_ff;

endmodule

// File: sv/tea_cell.sv
// One half-round cell of the TEA chain: a registered stage with its own handshake.
// Depends on tea_pkg for the word pair type and the mixing function.

module tea_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  tea_pkg::word_type      key_a,
   input  tea_pkg::word_type      key_b,
   input  tea_pkg::word_type      sum,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  tea_pkg::word_pair_type in_word,
   output logic                   out_valid,
   input  logic                   out_ready,
   output tea_pkg::word_pair_type out_word
);

   logic                   valid_ff;
   logic                   valid_in;
   tea_pkg::word_pair_type word_ff;
   tea_pkg::word_pair_type word_in;

   // The stage takes a new word when it is empty or its word moves on.
   assign in_ready = !valid_ff || out_ready;

   // Half round: the right half is mixed into the left, and the halves swap,
   // so that two cells in a row make one full round in the original order.
   always_comb begin
      word_in.left  = in_word.right;
      word_in.right = in_word.left + tea_pkg::mix_word(in_word.right, sum, key_a, key_b);
      valid_in      = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

// File: sv/tea_block_encrypt_core.sv
// Top level of the TEA block encryption core: key registers and the chain of cells.
// Depends on tea_pkg, tea_req_if, tea_rsp_if, tea_key_regs and tea_cell.

// The core encrypts one 64-bit block, given as two 32-bit words, with 32 rounds
// of the Tiny Encryption Algorithm under a 128-bit key held in four registers.
// The rounds run in a chain of 64 half-round cells, each a registered stage, so
// a block is accepted every cycle as long as no stage stalls for back-pressure;
// the last cell doubles as the output register. Each cell stalls only when it
// holds a word that cannot move on, so empty stages still take new blocks while
// a result waits. Key registers are written at indexes 0 to 3; other indexes are
// ignored. The key is read live, so it should only change with the chain empty.

module tea_block_encrypt_core (
   input  logic                                 clock,
   input  logic                                 reset,
   tea_req_if.sink                              req_chan,
   tea_rsp_if.source                            rsp_chan,
   input  logic                                 csr_we,
   input  logic [tea_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  tea_pkg::word_type                    csr_wdata
);

   tea_pkg::key_type       key;
   logic                   link_valid [tea_pkg::CELL_COUNT+1];
   logic                   link_ready [tea_pkg::CELL_COUNT+1];
   tea_pkg::word_pair_type link_word  [tea_pkg::CELL_COUNT+1];

   // Key registers.
   tea_key_regs key_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .key       (key)
   );

   // The request word enters the head of the chain.
   assign link_valid[0]      = req_chan.valid;
   assign req_chan.ready     = link_ready[0];
   assign link_word[0].left  = req_chan.plain_left;
   assign link_word[0].right = req_chan.plain_right;

   // Chain of half-round cells; even cells use the first key pair, odd the second.
   for (genvar i = 0; i < tea_pkg::CELL_COUNT; i++) begin : g_cell
      tea_cell cell_stage (
         .clock     (clock),
         .reset     (reset),
         .key_a     ((i % 2 == 0) ? key[0] : key[2]),
         .key_b     ((i % 2 == 0) ? key[1] : key[3]),
         .sum       (tea_pkg::round_sum(i / 2)),
         .in_valid  (link_valid[i]),
         .in_ready  (link_ready[i]),
         .in_word   (link_word[i]),
         .out_valid (link_valid[i+1]),
         .out_ready (link_ready[i+1]),
         .out_word  (link_word[i+1])
      );
   end

   // The tail of the chain drives the response word.
   assign rsp_chan.valid                 = link_valid[tea_pkg::CELL_COUNT];
   assign link_ready[tea_pkg::CELL_COUNT] = rsp_chan.ready;
   assign rsp_chan.cipher_left           = link_word[tea_pkg::CELL_COUNT].left;
   assign rsp_chan.cipher_right          = link_word[tea_pkg::CELL_COUNT].right;

endmodule

// File: tb/tea_block_encrypt_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for tea_block_encrypt_core: drives plaintext words and key writes
// and checks every ciphertext word against a behavioural TEA encryptor kept in this file.
// Depends on tea_pkg, tea_req_if, tea_rsp_if and the core itself.

module tea_block_encrypt_core_tb;

   localparam int RESET_CYCLES = 9;
   localparam int PHASE_BLOCKS = 170;
   localparam int PRESSURE_AFTER = 20;
   localparam int HOLD_CYCLES = 400;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 2 * tea_pkg::CELL_COUNT;
   localparam int CSR_INDEX_MAX = (1 << tea_pkg::CSR_INDEX_WIDTH) - 1;

   typedef logic [tea_pkg::CSR_INDEX_WIDTH-1:0] csr_index_type;

   // Key settings visited one after another once the directed words are done.
   typedef enum int {
      KEY_ZERO,
      KEY_ONES,
      KEY_RANDOM_A,
      KEY_RANDOM_B,
      KEY_PARTIAL,
      KEY_RESTORE,
      KEY_PLAN_COUNT
   } key_plan_type;

   // Directed plaintext words: extremes, alternating patterns and bits at the shift edges.
   localparam int PLAIN_TABLE_SIZE = 14;
   localparam tea_pkg::word_pair_type PLAIN_TABLE [PLAIN_TABLE_SIZE] = '{
      '{32'h0000_0000, 32'h0000_0000},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF},
      '{32'h0000_0000, 32'hFFFF_FFFF},
      '{32'hFFFF_FFFF, 32'h0000_0000},
      '{32'hAAAA_AAAA, 32'h5555_5555},
      '{32'h5555_5555, 32'hAAAA_AAAA},
      '{32'h8000_0000, 32'h0000_0001},
      '{32'h0000_0001, 32'h8000_0000},
      '{32'h7FFF_FFFF, 32'hFFFF_FFFE},
      '{32'h0000_000F, 32'hF000_0000},
      '{32'hF800_0000, 32'h0000_001F},
      '{32'h0000_001F, 32'hF800_0000},
      '{32'h0123_4567, 32'h89AB_CDEF},
      '{32'hDEAD_BEEF, 32'h0BAD_F00D}
   };

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   csr_index_type        csr_index;
   tea_pkg::word_type    csr_wdata;

   tea_req_if req_bus ();
   tea_rsp_if rsp_bus ();

   tea_block_encrypt_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Key as the core should hold it, ciphertext words still owed, and run status.
   tea_pkg::key_type        cipher_key;
   tea_pkg::word_pair_type  cipher_queue [$];
   int                      fail_count = 0;
   int                      sender_idle_pct = 0;
   int                      receiver_idle_pct = 0;
   bit                      hold_pending = 1'b0;
   int                      quiet_cycles = 0;

   // Clock with a 10 ns period.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Behavioural TEA: 32 rounds, all sums wrapping at 32 bits.
   function automatic tea_pkg::word_pair_type predict_cipher(
      input tea_pkg::word_pair_type plain, input tea_pkg::key_type key);
      tea_pkg::word_type      v0;
      tea_pkg::word_type      v1;
      tea_pkg::word_type      running_sum;
      tea_pkg::word_pair_type cipher;
      v0 = plain.left;
      v1 = plain.right;
      running_sum = '0;
      for (int r = 0; r < tea_pkg::ROUND_COUNT; r++) begin
         running_sum = running_sum + tea_pkg::TEA_DELTA;
         v0 = v0 + (((v1 << 4) + key[tea_pkg::KEY_WORD0_INDEX]) ^ (v1 + running_sum)
                    ^ ((v1 >> 5) + key[tea_pkg::KEY_WORD1_INDEX]));
         v1 = v1 + (((v0 << 4) + key[tea_pkg::KEY_WORD2_INDEX]) ^ (v0 + running_sum)
                    ^ ((v0 >> 5) + key[tea_pkg::KEY_WORD3_INDEX]));
      end
      cipher.left = v0;
      cipher.right = v1;
      return cipher;
   endfunction

   // Random half of a block, leaning now and then towards the extremes and single bits.
   function automatic tea_pkg::word_type random_half();
      int pick;
      pick = $urandom_range(9);
      if (pick == 0)
         return '0;
      else if (pick == 1)
         return '1;
      else if (pick == 2)
         return tea_pkg::word_type'(1) << $urandom_range(tea_pkg::WORD_WIDTH - 1);
      else
         return $urandom;
   endfunction

   // Offer one plaintext word, idling first at the sender's rate, and record its ciphertext.
   task automatic send_block(input tea_pkg::word_pair_type plain);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.plain_left <= plain.left;
      req_bus.plain_right <= plain.right;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      cipher_queue.push_back(predict_cipher(plain, cipher_key));
   endtask

   // One register write; the enable is left high for a following write.
   task automatic write_csr(input csr_index_type index, input tea_pkg::word_type data);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      if (index < tea_pkg::KEY_WORD_COUNT)
         cipher_key[index[1:0]] = data;
   endtask

   // Stop offering and wait until every owed ciphertext word has come back.
   task automatic drain_chain();
      req_bus.valid <= 1'b0;
      while (cipher_queue.size() != 0)
         @(posedge clock);
   endtask

   // Receiver: random back-pressure, plus one long hold-off when asked for.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_bus.ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // Compare each ciphertext word with the oldest one owed.
   always @(posedge clock) begin
      tea_pkg::word_pair_type due;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (cipher_queue.size() == 0) begin
            $display("%0t: unexpected ciphertext word, expected none, actual %h %h",
                     $time, rsp_bus.cipher_left, rsp_bus.cipher_right);
            fail_count++;
         end else begin
            due = cipher_queue.pop_front();
            if (rsp_bus.cipher_left !== due.left) begin
               $display("%0t: cipher_left mismatch, expected %h, actual %h",
                        $time, due.left, rsp_bus.cipher_left);
               fail_count++;
            end
            if (rsp_bus.cipher_right !== due.right) begin
               $display("%0t: cipher_right mismatch, expected %h, actual %h",
                        $time, due.right, rsp_bus.cipher_right);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: too long without any word moving on either channel ends the run.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Stimulus: reset, directed words under the reset key, then one phase per key setting.
   initial begin
      key_plan_type     plan;
      tea_pkg::key_type next_key;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.plain_left = '0;
      req_bus.plain_right = '0;
      cipher_key = {tea_pkg::KEY_WORD3_RESET, tea_pkg::KEY_WORD2_RESET,
                    tea_pkg::KEY_WORD1_RESET, tea_pkg::KEY_WORD0_RESET};
      sender_idle_pct = 17;
      receiver_idle_pct = 73;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed words check the key that reset leaves behind.
      for (int i = 0; i < PLAIN_TABLE_SIZE; i++)
         send_block(PLAIN_TABLE[i]);

      for (int p = 0; p < KEY_PLAN_COUNT; p++) begin
         plan = key_plan_type'(p);
         drain_chain();

         // Choose the key for this phase.
         case (plan)
            KEY_ZERO:    next_key = '0;
            KEY_ONES:    next_key = '1;
            KEY_RESTORE: next_key = {tea_pkg::KEY_WORD3_RESET, tea_pkg::KEY_WORD2_RESET,
                                     tea_pkg::KEY_WORD1_RESET, tea_pkg::KEY_WORD0_RESET};
            default: begin
               for (int k = 0; k < tea_pkg::KEY_WORD_COUNT; k++)
                  next_key[k] = $urandom;
            end
         endcase

         // Write the key; the partial phase rewrites only the odd key words.
         for (int k = 0; k < tea_pkg::KEY_WORD_COUNT; k++) begin
            if (plan != KEY_PARTIAL || k[0])
               write_csr(csr_index_type'(k), next_key[k]);
         end

         // Writes to unmapped indexes must leave the key alone.
         if (plan == KEY_ZERO)
            write_csr(csr_index_type'(CSR_INDEX_MAX), '1);
         write_csr(csr_index_type'($urandom_range(CSR_INDEX_MAX, tea_pkg::KEY_WORD_COUNT)),
                   $urandom);
         csr_we <= 1'b0;

         // Sender idles lightly and receiver heavily, then the reverse, then neither.
         case (plan)
            KEY_ZERO, KEY_ONES: begin
               sender_idle_pct = 17;
               receiver_idle_pct = 73;
            end
            KEY_RANDOM_A, KEY_RANDOM_B: begin
               sender_idle_pct = 73;
               receiver_idle_pct = 17;
            end
            default: begin
               sender_idle_pct = 0;
               receiver_idle_pct = 0;
            end
         endcase

         for (int n = 0; n < PHASE_BLOCKS; n++) begin
            if (plan == KEY_RESTORE && n == PRESSURE_AFTER)
               hold_pending = 1'b1;
            send_block('{random_half(), random_half()});
         end
      end

      // Let the chain empty, then watch a while longer for stray words.
      drain_chain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
